/* rtl/core/lpt_pkg.sv */
// ----------------------------------------------------------------------------
// lpt_pkg: shared types and constants of the page translator
// Field widths, page geometry, and the row and result records that travel
// between the frame table, the lookup logic, and the top level.
// ----------------------------------------------------------------------------
package lpt_pkg;

    // Page geometry. These are fixed by the widths of the port fields.
    localparam int FRAME_COUNT  = 4;
    localparam int PAGE_WORDS   = 4;
    localparam int VA_BITS      = 8;
    localparam int OFFSET_W     = $clog2(PAGE_WORDS);
    localparam int PAGE_W       = VA_BITS - OFFSET_W;
    localparam int FRAME_W      = $clog2(FRAME_COUNT);
    localparam int PHYS_W       = FRAME_W + OFFSET_W;
    localparam int PROCESS_W    = 3;
    localparam int LIMIT_W      = 6;
    localparam int AGE_W        = 16;

    localparam int PROCESS_COUNT_DEFAULT = 6;

    localparam logic [AGE_W-1:0]   AGE_MAX     = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

    // One process's slice of the page table.
    typedef struct packed {
        logic [FRAME_COUNT-1:0][PAGE_W-1:0] pages;
        logic [FRAME_COUNT-1:0][AGE_W-1:0]  ages;
    } row_t;

    // Write-back of a row after a lookup.
    typedef struct packed {
        logic wr_en;
        row_t row;
    } row_upd_t;

    // One translation result.
    typedef struct packed {
        logic [PHYS_W-1:0] physical_address;
        logic              hit;
        logic [PAGE_W-1:0] evicted_page;
        logic              writeback_needed;
        logic              fill_from_page_file;
        logic              fill_from_program;
    } result_t;

endpackage

/* rtl/core/lru_page_translator.sv */
// ----------------------------------------------------------------------------
// lru_page_translator: per-process address translation with LRU replacement
// Translates a (process, virtual word address) pair to a physical frame
// address and manages page faults with least-recently-used eviction.
// ----------------------------------------------------------------------------
// Each input transfer names a process and a virtual word address. The block
// ages every frame of that process by one (saturating), then looks the
// virtual page up in that process's frames. A hit clears that frame's age
// and returns frame * PAGE_WORDS + offset. A fault evicts the oldest frame
// (lowest index on a tie), maps the new page there with its age cleared, and
// reports the evicted page, whether it needs write-back (evicted page at or
// below the page limit) and where the fill comes from (page file when the new
// page is at or below the limit, program when at or above; both on equality).
// A process number at or above PROCESS_COUNT leaves the tables untouched and
// yields an all-zero result. The block takes one transfer per cycle while the
// result register is not stalled: an input register feeds one pass of
// compare-and-select logic into a result register, and the table row is
// written back at the same edge the result is captured, so the next item
// always sees the updated row. m_valid rises once the item has moved from
// the input register into the result register. A stalled result register
// holds the input register, and the input side stalls once both hold an
// item. The page limit register resets to 2 and is written through the cfg
// channel, which is always ready; write it only while no translation is in flight.
// ----------------------------------------------------------------------------
module lru_page_translator
    import lpt_pkg::*;
#(
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data,

    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PROCESS_W-1:0] s_process,
    input  logic [VA_BITS-1:0]   s_virtual_address,

    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PHYS_W-1:0]    m_physical_address,
    output logic                 m_hit,
    output logic [PAGE_W-1:0]    m_evicted_page,
    output logic                 m_writeback_needed,
    output logic                 m_fill_from_page_file,
    output logic                 m_fill_from_program
);

    localparam int PROC_IDX_W = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
    localparam int IDX_EXT_W  = PROC_IDX_W + PROCESS_W;

    // Input stage
    logic                 in_valid_reg;
    logic [PROCESS_W-1:0] process_reg;
    logic [VA_BITS-1:0]   vaddr_reg;

    // Result stage
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    logic [LIMIT_W-1:0]   limit_reg;

    logic                 advance;
    logic                 fire;
    logic                 in_range;
    logic [IDX_EXT_W-1:0] proc_ext;
    logic [PROC_IDX_W-1:0] row_idx;

    row_t                 rd_row;
    row_upd_t             lk_upd;
    row_upd_t             tbl_upd;

    // The result register frees up when it is empty or being drained.
    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Out-of-range processes read row zero; the lookup masks the result.
    assign in_range = (int'(process_reg) < PROCESS_COUNT);
    assign proc_ext = IDX_EXT_W'(process_reg);
    assign row_idx  = in_range ? proc_ext[PROC_IDX_W-1:0] : '0;

    // Write the row back only when the item moves into the result register.
    always_comb begin
        tbl_upd       = lk_upd;
        tbl_upd.wr_en = lk_upd.wr_en && fire;
    end

    lpt_frame_table #(
        .PROCESS_COUNT (PROCESS_COUNT),
        .PROC_IDX_W    (PROC_IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .row_idx (row_idx),
        .upd     (tbl_upd),
        .rd_row  (rd_row)
    );

    lpt_lookup u_lookup (
        .in_range        (in_range),
        .virtual_address (vaddr_reg),
        .page_limit      (limit_reg),
        .row             (rd_row),
        .result          (result_next),
        .upd             (lk_upd)
    );

    // Page limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // Input register: load on every input transfer, drop once the item moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            process_reg <= s_process;
            vaddr_reg   <= s_virtual_address;
        end
    end

    // Result register: hold while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_physical_address    = result_reg.physical_address;
    assign m_hit                 = result_reg.hit;
    assign m_evicted_page        = result_reg.evicted_page;
    assign m_writeback_needed    = result_reg.writeback_needed;
    assign m_fill_from_page_file = result_reg.fill_from_page_file;
    assign m_fill_from_program   = result_reg.fill_from_program;

    // An item leaving the input register always lands in the result register.
    a_fire_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("item lost between input and result registers");

    // An empty result register never blocks the input side.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // An unknown process yields an all-zero result.
    a_bad_process: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !in_range) |=> (m_physical_address == '0 && !m_hit &&
            m_evicted_page == '0 && !m_writeback_needed &&
            !m_fill_from_page_file && !m_fill_from_program))
        else $error("nonzero result for out-of-range process");

    // A configuration transfer lands in the limit register.
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> (limit_reg == $past(cfg_data)))
        else $error("page limit write lost");

endmodule

/* rtl/core/lpt_frame_table.sv */
// ----------------------------------------------------------------------------
// lpt_frame_table: per-process frame map and age storage
// Holds one row of page numbers and age counters per process, read and
// written back at the same row index.
// ----------------------------------------------------------------------------
module lpt_frame_table
    import lpt_pkg::*;
#(
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEFAULT,
    parameter int PROC_IDX_W    = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [PROC_IDX_W-1:0] row_idx,
    input  row_upd_t              upd,
    output row_t                  rd_row
);

    row_t table_reg [PROCESS_COUNT];

    assign rd_row = table_reg[row_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PROCESS_COUNT; p++) begin
                for (int f = 0; f < FRAME_COUNT; f++) begin
                    table_reg[p].pages[f] <= PAGE_W'(f);
                    table_reg[p].ages[f]  <= '0;
                end
            end
        end else if (upd.wr_en) begin
            table_reg[row_idx] <= upd.row;
        end
    end

endmodule

/* rtl/core/lpt_lookup.sv */
// ----------------------------------------------------------------------------
// lpt_lookup: page search and least-recently-used victim choice
// Ages one row, searches it for the page, picks the oldest frame on a fault,
// and forms both the result and the updated row.
// ----------------------------------------------------------------------------
module lpt_lookup
    import lpt_pkg::*;
(
    input  logic               in_range,
    input  logic [VA_BITS-1:0] virtual_address,
    input  logic [LIMIT_W-1:0] page_limit,
    input  row_t               row,
    output result_t            result,
    output row_upd_t           upd
);

    logic [PAGE_W-1:0]                  page;
    logic [OFFSET_W-1:0]                offset;
    logic [FRAME_COUNT-1:0][AGE_W-1:0]  aged;
    logic                               found;
    logic [FRAME_W-1:0]                 hit_frame;
    logic [FRAME_W-1:0]                 victim;
    logic [AGE_W-1:0]                   best_age;
    logic [FRAME_W-1:0]                 frame;
    logic [PAGE_W-1:0]                  old_page;

    assign page   = virtual_address[VA_BITS-1:OFFSET_W];
    assign offset = virtual_address[OFFSET_W-1:0];

    // Saturating age step for every frame of the row.
    always_comb begin
        for (int f = 0; f < FRAME_COUNT; f++) begin
            aged[f] = (row.ages[f] == AGE_MAX) ? row.ages[f] : row.ages[f] + AGE_W'(1);
        end
    end

    // First matching frame wins.
    always_comb begin
        found     = 1'b0;
        hit_frame = '0;
        for (int f = 0; f < FRAME_COUNT; f++) begin
            if (!found && row.pages[f] == page) begin
                found     = 1'b1;
                hit_frame = FRAME_W'(f);
            end
        end
    end

    // Oldest frame, lowest index on a tie.
    always_comb begin
        victim   = '0;
        best_age = aged[0];
        for (int f = 1; f < FRAME_COUNT; f++) begin
            if (best_age < aged[f]) begin
                best_age = aged[f];
                victim   = FRAME_W'(f);
            end
        end
    end

    assign frame    = found ? hit_frame : victim;
    assign old_page = row.pages[victim];

    always_comb begin
        upd.wr_en            = in_range;
        upd.row.ages         = aged;
        upd.row.pages        = row.pages;
        upd.row.ages[frame]  = '0;
        if (!found) begin
            upd.row.pages[frame] = page;
        end
    end

    always_comb begin
        result = '0;
        if (in_range) begin
            result.physical_address = {frame, offset};
            result.hit              = found;
            if (!found) begin
                result.evicted_page        = old_page;
                result.writeback_needed    = (old_page <= page_limit);
                result.fill_from_page_file = (page <= page_limit);
                result.fill_from_program   = (page >= page_limit);
            end
        end
    end

endmodule

/* bench/lpt_checker.sv */
// ----------------------------------------------------------------------------
// lpt_checker: result checker for the page translator
// Watches the cfg, input and result channels, keeps its own per-process
// page table with LRU ages, predicts each translation and compares it field
// by field with what the block returns.
// ----------------------------------------------------------------------------
module lpt_checker
    import lpt_pkg::*;
#(
    parameter int PROCESS_COUNT = PROCESS_COUNT_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [PROCESS_W-1:0] s_process,
    input  logic [VA_BITS-1:0]   s_virtual_address,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PHYS_W-1:0]    m_physical_address,
    input  logic                 m_hit,
    input  logic [PAGE_W-1:0]    m_evicted_page,
    input  logic                 m_writeback_needed,
    input  logic                 m_fill_from_page_file,
    input  logic                 m_fill_from_program,

    output int                   fail_count,
    output int                   outstanding
);

    logic [PAGE_W-1:0]  frame_page [PROCESS_COUNT][FRAME_COUNT];
    logic [AGE_W-1:0]   frame_age  [PROCESS_COUNT][FRAME_COUNT];
    logic [LIMIT_W-1:0] page_limit;
    result_t            translations_due[$];

    // Age the process, look the page up, and replace the oldest frame on a fault.
    function automatic result_t translate(input logic [PROCESS_W-1:0] proc,
                                          input logic [VA_BITS-1:0] vaddr);
        result_t             res;
        logic [PAGE_W-1:0]   vpage;
        logic [OFFSET_W-1:0] offs;
        logic [FRAME_W-1:0]  slot;
        logic                mapped;
        res = '0;
        if (proc >= PROCESS_COUNT) return res;
        vpage  = vaddr[VA_BITS-1:OFFSET_W];
        offs   = vaddr[OFFSET_W-1:0];
        slot   = '0;
        mapped = 1'b0;
        for (int f = 0; f < FRAME_COUNT; f++) begin
            if (frame_age[proc][f] != AGE_MAX) frame_age[proc][f] = frame_age[proc][f] + 1'b1;
        end
        for (int f = 0; f < FRAME_COUNT; f++) begin
            if (!mapped && frame_page[proc][f] == vpage) begin
                slot   = FRAME_W'(f);
                mapped = 1'b1;
            end
        end
        if (mapped) begin
            res.hit = 1'b1;
        end else begin
            // strict compare keeps the lowest index on equal ages
            for (int f = 1; f < FRAME_COUNT; f++) begin
                if (frame_age[proc][slot] < frame_age[proc][f]) slot = FRAME_W'(f);
            end
            res.evicted_page        = frame_page[proc][slot];
            res.writeback_needed    = (frame_page[proc][slot] <= page_limit);
            res.fill_from_page_file = (vpage <= page_limit);
            res.fill_from_program   = (vpage >= page_limit);
            frame_page[proc][slot]  = vpage;
        end
        frame_age[proc][slot] = '0;
        res.physical_address  = {slot, offs};
        return res;
    endfunction

    function automatic bit field_matches(input string label, input logic [7:0] want,
                                         input logic [7:0] seen);
        if (seen === want) return 1'b1;
        $display("%0t: %s expected %0h actual %0h", $time, label, want, seen);
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        bit      ok;
        if (!aresetn) begin
            for (int p = 0; p < PROCESS_COUNT; p++) begin
                for (int f = 0; f < FRAME_COUNT; f++) begin
                    frame_page[p][f] = PAGE_W'(f);
                    frame_age[p][f]  = '0;
                end
            end
            page_limit = LIMIT_RESET;
            translations_due.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) page_limit = cfg_data;
            if (m_valid && m_ready) begin
                seen = {m_physical_address, m_hit, m_evicted_page, m_writeback_needed,
                        m_fill_from_page_file, m_fill_from_program};
                if (translations_due.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, seen);
                    fail_count <= fail_count + 1;
                end else begin
                    want = translations_due.pop_front();
                    ok = field_matches("physical_address", 8'(want.physical_address),
                                       8'(seen.physical_address))
                       & field_matches("hit", 8'(want.hit), 8'(seen.hit))
                       & field_matches("evicted_page", 8'(want.evicted_page),
                                       8'(seen.evicted_page))
                       & field_matches("writeback_needed", 8'(want.writeback_needed),
                                       8'(seen.writeback_needed))
                       & field_matches("fill_from_page_file", 8'(want.fill_from_page_file),
                                       8'(seen.fill_from_page_file))
                       & field_matches("fill_from_program", 8'(want.fill_from_program),
                                       8'(seen.fill_from_program));
                    if (!ok) fail_count <= fail_count + 1;
                end
            end
            if (s_valid && s_ready) begin
                translations_due.push_back(translate(s_process, s_virtual_address));
            end
        end
        outstanding <= translations_due.size();
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top for lru_page_translator
// Drives directed translations (hits, faults, out-of-range processes, page at
// the limit, limit extremes), a stretch on one process that checks the LRU
// order, and random traffic over several page limits, with random idling on
// both sides. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import lpt_pkg::*;

    localparam int PROCESS_COUNT = PROCESS_COUNT_DEFAULT;
    localparam int CLK_HALF      = 6;
    localparam int TIMEOUT_CYCLES = 600000;

    logic                 aclk;
    logic                 aresetn               = 1'b0;
    logic                 cfg_valid             = 1'b0;
    logic                 cfg_ready;
    logic [LIMIT_W-1:0]   cfg_data              = '0;
    logic                 s_valid               = 1'b0;
    logic                 s_ready;
    logic [PROCESS_W-1:0] s_process             = '0;
    logic [VA_BITS-1:0]   s_virtual_address     = '0;
    logic                 m_valid;
    logic                 m_ready               = 1'b0;
    logic [PHYS_W-1:0]    m_physical_address;
    logic                 m_hit;
    logic [PAGE_W-1:0]    m_evicted_page;
    logic                 m_writeback_needed;
    logic                 m_fill_from_page_file;
    logic                 m_fill_from_program;

    int                   fail_count;
    int                   outstanding;

    // quiet turns idling off on both sides for a stretch of items
    bit                   quiet = 1'b0;
    int unsigned          ready_hold = 0;
    int unsigned          ready_draw;
    logic [LIMIT_W-1:0]   page_limit = LIMIT_RESET;

    lru_page_translator #(
        .PROCESS_COUNT(PROCESS_COUNT)
    ) i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_process            (s_process),
        .s_virtual_address    (s_virtual_address),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_physical_address   (m_physical_address),
        .m_hit                (m_hit),
        .m_evicted_page       (m_evicted_page),
        .m_writeback_needed   (m_writeback_needed),
        .m_fill_from_page_file(m_fill_from_page_file),
        .m_fill_from_program  (m_fill_from_program)
    );

    lpt_checker #(
        .PROCESS_COUNT(PROCESS_COUNT)
    ) i_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_process            (s_process),
        .s_virtual_address    (s_virtual_address),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_physical_address   (m_physical_address),
        .m_hit                (m_hit),
        .m_evicted_page       (m_evicted_page),
        .m_writeback_needed   (m_writeback_needed),
        .m_fill_from_page_file(m_fill_from_page_file),
        .m_fill_from_program  (m_fill_from_program),
        .fail_count           (fail_count),
        .outstanding          (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Result side: after each transfer, draw a stall and hold ready low for it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (m_valid && m_ready) begin
            ready_draw = quiet ? 0 : $urandom_range(0, 19);
            ready_hold <= ready_draw;
            m_ready    <= (ready_draw == 0);
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= (ready_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Present one translation request and hold it until the transfer.
    // Valid drops only when a gap is drawn, so back-to-back items keep it high.
    task automatic send_item(input logic [PROCESS_W-1:0] proc,
                             input logic [VA_BITS-1:0] vaddr);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_process         <= proc;
        s_virtual_address <= vaddr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid, drain every pending translation, then write the page limit.
    task automatic set_page_limit(input logic [LIMIT_W-1:0] lim);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        page_limit = lim;
    endtask

    // Random traffic: mostly a small page pool so hits and LRU evictions recur,
    // some pages around the limit, some anywhere, and a share of bad processes.
    task automatic run_random_phase(input int count);
        logic [PROCESS_W-1:0] proc;
        logic [PAGE_W-1:0]    vpage;
        int unsigned          pick;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                proc = PROCESS_W'($urandom_range(PROCESS_COUNT, (1 << PROCESS_W) - 1));
            end else begin
                proc = PROCESS_W'($urandom_range(0, PROCESS_COUNT - 1));
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                vpage = PAGE_W'($urandom_range(0, 7));
            end else if (pick < 8) begin
                vpage = PAGE_W'(page_limit) + PAGE_W'($urandom_range(0, 2)) - 1'b1;
            end else begin
                vpage = PAGE_W'($urandom());
            end
            send_item(proc, {vpage, OFFSET_W'($urandom())});
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        wait (aresetn);
        @(posedge aclk);

        // Directed part, page limit at its reset value.
        send_item(3'd0, 8'h00);          // hit on frame 0
        send_item(3'd0, 8'hFF);          // fault on the top page
        send_item(3'd1, 8'h0B);          // hit on the page equal to the limit
        send_item(3'd6, 8'hFF);          // process out of range
        send_item(3'd7, 8'h00);
        send_item(3'd5, 8'h07);          // hits with the top offset
        send_item(3'd5, 8'h0F);
        // Walk process 2 through faults until page 2 comes back in at the limit.
        send_item(3'd2, 8'h10);
        send_item(3'd2, 8'h15);
        send_item(3'd2, 8'h1A);
        send_item(3'd2, 8'h09);
        send_item(3'd2, 8'h0A);          // hit on the refilled page

        // Limit at zero: page 0 refilled sets both fill flags.
        set_page_limit('0);
        send_item(3'd4, 8'h20);
        send_item(3'd4, 8'h01);
        send_item(3'd4, 8'h03);

        // Limit at the top: page 63 filled sets both fill flags.
        set_page_limit('1);
        send_item(3'd4, 8'hFC);
        send_item(3'd4, 8'hAA);
        send_item(3'd6, 8'h55);

        // Hammer frame 0 of process 3 so frames 1 and 2 grow far older than
        // frame 3, touched once early. The following faults must evict
        // frames 1 and 2, not frame 3.
        quiet = 1'b1;
        repeat (20) send_item(3'd3, 8'h01);
        send_item(3'd3, 8'h0E);
        repeat (40) send_item(3'd3, 8'h02);
        send_item(3'd3, 8'hA1);
        send_item(3'd3, 8'hA6);
        send_item(3'd3, 8'h0C);

        // Random part across several limits, extremes included.
        set_page_limit('0);
        run_random_phase(130);
        set_page_limit('1);
        run_random_phase(130);
        set_page_limit(LIMIT_W'($urandom()));
        run_random_phase(130);
        set_page_limit(LIMIT_W'(31));
        run_random_phase(130);
        set_page_limit(LIMIT_W'($urandom()));
        run_random_phase(130);
        set_page_limit(LIMIT_W'($urandom()));
        run_random_phase(130);
        set_page_limit(LIMIT_RESET);
        run_random_phase(130);

        // Drain and let any stray result show up before the verdict.
        s_valid <= 1'b0;
        quiet = 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop if the block hangs.
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/lpt_pkg.sv
rtl/core/lpt_frame_table.sv
rtl/core/lpt_lookup.sv
rtl/core/lru_page_translator.sv
bench/lpt_checker.sv
bench/tb.sv
